[hw/rtl/bdtc_pkg.sv]
// Package: constants, types and helper functions of the block device tag controller.
`timescale 1ns / 1ps
package bdtc_pkg;

  localparam int unsigned TAGS = 8;
  localparam int unsigned TagW = $clog2(TAGS);
  localparam int unsigned CntW = $clog2(TAGS + 1);

  // item opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register map (byte offsets)
  localparam logic [11:0] REG_ADDRESS   = 12'd0;
  localparam logic [11:0] REG_SECTOR    = 12'd8;
  localparam logic [11:0] REG_COUNT     = 12'd12;
  localparam logic [11:0] REG_DIRECTION = 12'd16;
  localparam logic [11:0] REG_REQUEST   = 12'd17;
  localparam logic [11:0] REG_IDLE_CNT  = 12'd18;
  localparam logic [11:0] REG_COMPLETE  = 12'd19;
  localparam logic [11:0] REG_DONE_CNT  = 12'd20;
  localparam logic [11:0] REG_SECTORS   = 12'd24;
  localparam logic [11:0] REG_MAX_LEN   = 12'd28;

  // configuration register indexes
  localparam logic [1:0] CFG_SECTOR_COUNT = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH   = 2'd1;
  localparam logic [1:0] CFG_TICK_PERIOD  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_UNMAPPED = 3'd1;
  localparam logic [2:0] ERR_NO_IDLE  = 3'd2;
  localparam logic [2:0] ERR_NO_DONE  = 3'd3;
  localparam logic [2:0] ERR_ALIGN    = 3'd4;
  localparam logic [2:0] ERR_LENGTH   = 3'd5;
  localparam logic [2:0] ERR_RANGE    = 3'd6;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [TagW-1:0] tag;
  } fifo_ctl_t;

  typedef struct packed {
    logic [TagW-1:0] head;
    logic [CntW-1:0] count;
  } fifo_sts_t;

  // all-ones in the low n bytes
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    if (n >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

  // replace the low min(size, regbytes) bytes of old
  function automatic logic [63:0] merge(input logic [63:0] old, input logic [3:0] regbytes,
                                        input logic [3:0] size, input logic [63:0] data);
    logic [3:0]  k;
    logic [63:0] m;
    k = (size < regbytes) ? size : regbytes;
    m = byte_mask(k);
    return (old & ~m) | (data & m);
  endfunction

endpackage

[hw/rtl/bdtc_in_if.sv]
// Interface: input item channel (bus access or time tick).
`timescale 1ns / 1ps
interface bdtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] addr;
  logic [3:0]  size;
  logic [63:0] wdata;

  modport source (output valid, op, addr, size, wdata, input ready);
  modport sink   (input valid, op, addr, size, wdata, output ready);
endinterface

[hw/rtl/bdtc_out_if.sv]
// Interface: result item channel (read data, error, interrupt, DMA command).
`timescale 1ns / 1ps
interface bdtc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] rdata;
  logic [2:0]  error;
  logic        irq;
  logic        issue;
  logic        issue_write;
  logic [63:0] issue_address;
  logic [31:0] issue_sector;
  logic [31:0] issue_count;
  logic [2:0]  issue_tag;

  modport source (output valid, rdata, error, irq, issue, issue_write, issue_address,
                  issue_sector, issue_count, issue_tag, input ready);
  modport sink   (input valid, rdata, error, irq, issue, issue_write, issue_address,
                  issue_sector, issue_count, issue_tag, output ready);
endinterface

[hw/rtl/bdtc_tag_fifo.sv]
// Tag FIFO: circular queue of request tags with head pointer and fill count.
`timescale 1ns / 1ps
module bdtc_tag_fifo import bdtc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rst_full_i,
  input  fifo_ctl_t ctl_i,
  output fifo_sts_t sts_o
);

  logic [TagW-1:0] slot_q [TAGS];
  logic [TagW-1:0] head_q;
  logic [CntW-1:0] cnt_q;
  logic [TagW-1:0] wr_idx;

  assign wr_idx = head_q + cnt_q[TagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= rst_full_i ? CntW'(TAGS) : '0;
      for (int i = 0; i < TAGS; i++) begin
        slot_q[i] <= TagW'(i);
      end
    end else begin
      if (ctl_i.push) begin
        slot_q[wr_idx] <= ctl_i.tag;
      end
      if (ctl_i.pop) begin
        head_q <= head_q + TagW'(1);
      end
      if (ctl_i.push && !ctl_i.pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (ctl_i.pop && !ctl_i.push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign sts_o.head  = slot_q[head_q];
  assign sts_o.count = cnt_q;

endmodule

[hw/rtl/block_device_tag_controller_unit.sv]
// Top level: register front end and tick scheduler of the tagged block device.
//
// Usage: in_i carries one item per handshake: a register read, a register
// write or a time tick. out_o returns exactly one result item per input item,
// in order: read data, error code, interrupt level after the item and, on a
// serviced tick, the DMA command. cfg_we_i/cfg_index_i/cfg_wdata_i write
// sector_count (0), max_length (1) and tick_period (2); the user must do so
// only while the block idles, the block itself does not enforce it. An item
// is captured in the input register and, when it fires, processed into the
// result register. Throughput: one item per cycle unless the receiver stalls
// or the remainder unit runs; the input and result registers decouple the
// two sides, so an item is still taken while one result waits.
// A tick_period write starts a bit-serial remainder of the tick count by the
// new period; in_i.ready stays low until it ends.
// Reset: request registers and tick count clear, the idle FIFO holds tags 0 to
// TAGS-1, pending and done FIFOs are empty, irq is low.
// When the receiver stalls, the result register holds; with the input
// register also full, in_i.ready drops until out_o.ready returns.
`timescale 1ns / 1ps
module block_device_tag_controller_unit import bdtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  bdtc_in_if.sink     in_i,
  bdtc_out_if.source  out_o
);

  // configuration
  logic [31:0] sector_count_q;
  logic [15:0] max_length_q;
  logic [15:0] tick_period_q;

  // input register
  logic        in_vld_q;
  logic [1:0]  op_q;
  logic [11:0] addr_q;
  logic [3:0]  size_q;
  logic [63:0] wdata_q;

  // block state
  logic [63:0] req_address_q, req_address_d;
  logic [31:0] req_sector_q, req_sector_d;
  logic [31:0] req_count_q, req_count_d;
  logic [7:0]  req_direction_q, req_direction_d;
  logic [15:0] tick_cnt_q, tick_cnt_d;
  logic [15:0] residue_q, residue_d;   // tick_cnt_q mod effective period
  logic        irq_q, irq_d;

  // remainder unit
  logic        div_busy_q;
  logic [3:0]  div_cnt_q;
  logic [15:0] div_rem_q;
  logic [16:0] div_trial;
  logic [15:0] div_rem_d;

  // result register
  logic        out_vld_q;
  logic [63:0] rdata_q, rdata_d;
  logic [2:0]  err_q, err_d;
  logic        issue_q, issue_d;
  logic        iwrite_q, iwrite_d;
  logic [63:0] iaddr_q, iaddr_d;
  logic [31:0] isector_q, isector_d;
  logic [31:0] icount_q, icount_d;
  logic [2:0]  itag_q, itag_d;

  fifo_ctl_t idle_ctl, pend_ctl, done_ctl;
  fifo_sts_t idle_sts, pend_sts, done_sts;

  logic        advance;
  logic        fire;
  logic [16:0] period;
  logic [16:0] next_res;
  logic        slot;

  bdtc_tag_fifo u_idle_fifo (
    .clk_i, .rst_ni, .rst_full_i(1'b1), .ctl_i(idle_ctl), .sts_o(idle_sts)
  );
  bdtc_tag_fifo u_pend_fifo (
    .clk_i, .rst_ni, .rst_full_i(1'b0), .ctl_i(pend_ctl), .sts_o(pend_sts)
  );
  bdtc_tag_fifo u_done_fifo (
    .clk_i, .rst_ni, .rst_full_i(1'b0), .ctl_i(done_ctl), .sts_o(done_sts)
  );

  assign advance     = !out_vld_q || out_o.ready;
  assign fire        = in_vld_q && advance && !div_busy_q;
  assign in_i.ready  = !div_busy_q && (!in_vld_q || fire);

  // zero period acts as one
  assign period   = (tick_period_q == 16'd0) ? 17'd1 : {1'b0, tick_period_q};
  assign next_res = {1'b0, residue_q} + 17'd1;
  assign slot     = (next_res == period);

  // restoring remainder, one dividend bit per cycle, msb first
  assign div_trial = {div_rem_q, tick_cnt_q[~div_cnt_q]};
  assign div_rem_d = (div_trial >= period) ? 16'(div_trial - period) : div_trial[15:0];

  always_comb begin
    req_address_d   = req_address_q;
    req_sector_d    = req_sector_q;
    req_count_d     = req_count_q;
    req_direction_d = req_direction_q;
    tick_cnt_d      = tick_cnt_q;
    residue_d       = residue_q;
    irq_d           = irq_q;
    idle_ctl        = '0;
    pend_ctl        = '0;
    done_ctl        = '0;
    rdata_d         = '0;
    err_d           = ERR_OK;
    issue_d         = 1'b0;
    iwrite_d        = 1'b0;
    iaddr_d         = '0;
    isector_d       = '0;
    icount_d        = '0;
    itag_d          = '0;

    unique case (op_q)
      OP_READ: begin
        if (size_q > 4'd8) begin
          err_d = ERR_UNMAPPED;
        end else begin
          unique case (addr_q)
            REG_REQUEST: begin
              if (idle_sts.count == '0) begin
                err_d = ERR_NO_IDLE;
              end else begin
                idle_ctl.pop  = 1'b1;
                pend_ctl.push = 1'b1;
                pend_ctl.tag  = idle_sts.head;
              end
            end
            REG_IDLE_CNT: rdata_d = 64'(idle_sts.count);
            REG_COMPLETE: begin
              if (done_sts.count == '0) begin
                err_d = ERR_NO_DONE;
              end else begin
                done_ctl.pop  = 1'b1;
                idle_ctl.push = 1'b1;
                idle_ctl.tag  = done_sts.head;
                rdata_d       = 64'(done_sts.head);
                if (done_sts.count == CntW'(1)) begin
                  irq_d = 1'b0;
                end
              end
            end
            REG_DONE_CNT: rdata_d = 64'(done_sts.count);
            REG_SECTORS:  rdata_d = {32'd0, sector_count_q};
            REG_MAX_LEN:  rdata_d = {48'd0, max_length_q};
            default:      err_d = ERR_UNMAPPED;
          endcase
        end
        rdata_d = rdata_d & byte_mask(size_q);
      end
      OP_WRITE: begin
        if (size_q > 4'd8) begin
          err_d = ERR_UNMAPPED;
        end else begin
          unique case (addr_q)
            REG_ADDRESS: req_address_d = merge(req_address_q, 4'd8, size_q, wdata_q);
            REG_SECTOR:
              req_sector_d = 32'(merge({32'd0, req_sector_q}, 4'd4, size_q, wdata_q));
            REG_COUNT:
              req_count_d = 32'(merge({32'd0, req_count_q}, 4'd4, size_q, wdata_q));
            REG_DIRECTION:
              req_direction_d = 8'(merge({56'd0, req_direction_q}, 4'd1, size_q, wdata_q));
            default: err_d = ERR_UNMAPPED;
          endcase
        end
      end
      OP_TICK: begin
        if (slot) begin
          tick_cnt_d = '0;
          residue_d  = '0;
        end else if (tick_cnt_q == 16'hFFFF) begin
          // 16-bit wrap of the count restarts the residue as well
          tick_cnt_d = '0;
          residue_d  = '0;
        end else begin
          tick_cnt_d = tick_cnt_q + 16'd1;
          residue_d  = next_res[15:0];
        end
        if (slot && pend_sts.count != '0) begin
          itag_d = 3'(pend_sts.head);
          if (req_address_q[2:0] != 3'd0) begin
            err_d = ERR_ALIGN;
          end else if (req_count_q == 32'd0 || req_count_q > {16'd0, max_length_q}) begin
            err_d = ERR_LENGTH;
          end else if (req_sector_q > sector_count_q ||
                       req_count_q > (sector_count_q - req_sector_q)) begin
            err_d = ERR_RANGE;
          end else begin
            issue_d       = 1'b1;
            iwrite_d      = (req_direction_q != 8'd0);
            iaddr_d       = req_address_q;
            isector_d     = req_sector_q;
            icount_d      = req_count_q;
            irq_d         = 1'b1;
            pend_ctl.pop  = 1'b1;
            done_ctl.push = 1'b1;
            done_ctl.tag  = pend_sts.head;
          end
        end
      end
      default: ;
    endcase

    if (!fire) begin
      idle_ctl = '0;
      pend_ctl = '0;
      done_ctl = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_count_q  <= '0;
      max_length_q    <= 16'd8;
      tick_period_q   <= 16'd1;
      in_vld_q        <= 1'b0;
      out_vld_q       <= 1'b0;
      req_address_q   <= '0;
      req_sector_q    <= '0;
      req_count_q     <= '0;
      req_direction_q <= '0;
      tick_cnt_q      <= '0;
      residue_q       <= '0;
      irq_q           <= 1'b0;
      div_busy_q      <= 1'b0;
      div_cnt_q       <= '0;
      div_rem_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SECTOR_COUNT: sector_count_q <= cfg_wdata_i;
          CFG_MAX_LENGTH:   max_length_q   <= cfg_wdata_i[15:0];
          CFG_TICK_PERIOD: begin
            tick_period_q <= cfg_wdata_i[15:0];
            div_busy_q    <= 1'b1;
            div_cnt_q     <= '0;
            div_rem_q     <= '0;
          end
          default: ;
        endcase
      end
      if (div_busy_q && !(cfg_we_i && cfg_index_i == CFG_TICK_PERIOD)) begin
        div_rem_q <= div_rem_d;
        div_cnt_q <= div_cnt_q + 4'd1;
        if (div_cnt_q == 4'd15) begin
          div_busy_q <= 1'b0;
          residue_q  <= div_rem_d;
        end
      end

      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end

      if (fire) begin
        out_vld_q       <= 1'b1;
        req_address_q   <= req_address_d;
        req_sector_q    <= req_sector_d;
        req_count_q     <= req_count_d;
        req_direction_q <= req_direction_d;
        tick_cnt_q      <= tick_cnt_d;
        residue_q       <= residue_d;
        irq_q           <= irq_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= in_i.op;
      addr_q  <= in_i.addr;
      size_q  <= in_i.size;
      wdata_q <= in_i.wdata;
    end
    if (fire) begin
      rdata_q   <= rdata_d;
      err_q     <= err_d;
      issue_q   <= issue_d;
      iwrite_q  <= iwrite_d;
      iaddr_q   <= iaddr_d;
      isector_q <= isector_d;
      icount_q  <= icount_d;
      itag_q    <= itag_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.rdata         = rdata_q;
  assign out_o.error         = err_q;
  assign out_o.irq           = irq_q;
  assign out_o.issue         = issue_q;
  assign out_o.issue_write   = iwrite_q;
  assign out_o.issue_address = iaddr_q;
  assign out_o.issue_sector  = isector_q;
  assign out_o.issue_count   = icount_q;
  assign out_o.issue_tag     = itag_q;

  // every tag lives in exactly one of the three FIFOs
  a_tag_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(idle_sts.count) + 32'(pend_sts.count) + 32'(done_sts.count)) == TAGS)
    else $error("tag count not conserved across FIFOs");

  // interrupt level tracks a non-empty completion FIFO
  a_irq_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_q == (done_sts.count != '0))
    else $error("irq level disagrees with completion FIFO");

  // an issued command never carries an error
  a_issue_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && issue_q) |-> (err_q == ERR_OK && irq_q))
    else $error("issued command with error or without irq");

  // no item is processed while the remainder unit runs
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |=> $stable(tick_cnt_q))
    else $error("tick count moved during remainder pass");

endmodule

[tb/sv/bdtc_response_checker.sv]
// Checker: predicts every result item of the tag controller and compares it with the DUT.
`timescale 1ns / 1ps
module bdtc_response_checker import bdtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  bdtc_in_if          in_mon_i,
  bdtc_out_if         out_mon_i,
  output int          mismatch_cnt_o,
  output int          awaited_cnt_o
);

  typedef struct packed {
    logic [63:0] rdata;
    logic [2:0]  error;
    logic        irq;
    logic        issue;
    logic        issue_write;
    logic [63:0] issue_address;
    logic [31:0] issue_sector;
    logic [31:0] issue_count;
    logic [2:0]  issue_tag;
  } dev_resp_t;

  // configuration copy
  logic [31:0] disk_sectors;
  logic [15:0] len_limit;
  logic [15:0] slot_period;

  // request registers, tag queues and scheduler state
  logic [63:0]     dma_addr;
  logic [31:0]     dma_sector;
  logic [31:0]     dma_count;
  logic [7:0]      dma_dir;
  logic [TagW-1:0] idle_tags[$];
  logic [TagW-1:0] pending_tags[$];
  logic [TagW-1:0] done_tags[$];
  logic [15:0]     tick_cnt;
  logic            irq_q;

  dev_resp_t awaited_resps[$];
  int        mismatches = 0;

  assign mismatch_cnt_o = mismatches;

  function automatic logic [63:0] lane_mask(input int unsigned nbytes);
    if (nbytes >= 8) return '1;
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  function automatic logic [63:0] merge_bytes(input logic [63:0] old, input int unsigned reg_bytes,
                                              input int unsigned size, input logic [63:0] data);
    logic [63:0] m;
    m = lane_mask((size < reg_bytes) ? size : reg_bytes);
    return (old & ~m) | (data & m);
  endfunction

  task automatic reset_model();
    disk_sectors = '0;
    len_limit    = 16'd8;
    slot_period  = 16'd1;
    dma_addr     = '0;
    dma_sector   = '0;
    dma_count    = '0;
    dma_dir      = '0;
    idle_tags.delete();
    pending_tags.delete();
    done_tags.delete();
    for (int i = 0; i < TAGS; i++) idle_tags.push_back(i[TagW-1:0]);
    tick_cnt = '0;
    irq_q    = 1'b0;
  endtask

  task automatic predict_response(input logic [1:0] op, input logic [11:0] addr,
                                  input logic [3:0] size, input logic [63:0] wdata,
                                  output dev_resp_t r);
    logic [TagW-1:0] tag;
    logic [31:0]     period;
    logic [31:0]     next_cnt;
    logic [63:0]     merged;
    logic            slot;
    r = '0;
    case (op)
      OP_READ: begin
        if (size > 4'd8) begin
          r.error = ERR_UNMAPPED;
        end else begin
          case (addr)
            REG_REQUEST: begin
              if (idle_tags.size() == 0) r.error = ERR_NO_IDLE;
              else pending_tags.push_back(idle_tags.pop_front());
            end
            REG_IDLE_CNT: r.rdata = 64'(idle_tags.size());
            REG_COMPLETE: begin
              if (done_tags.size() == 0) begin
                r.error = ERR_NO_DONE;
              end else begin
                tag = done_tags.pop_front();
                r.rdata = 64'(tag);
                idle_tags.push_back(tag);
                if (done_tags.size() == 0) irq_q = 1'b0;
              end
            end
            REG_DONE_CNT: r.rdata = 64'(done_tags.size());
            REG_SECTORS:  r.rdata = {32'b0, disk_sectors};
            REG_MAX_LEN:  r.rdata = {48'b0, len_limit};
            default:      r.error = ERR_UNMAPPED;
          endcase
        end
        r.rdata &= lane_mask(size);
      end
      OP_WRITE: begin
        if (size > 4'd8) begin
          r.error = ERR_UNMAPPED;
        end else begin
          case (addr)
            REG_ADDRESS: dma_addr = merge_bytes(dma_addr, 8, size, wdata);
            REG_SECTOR: begin
              merged = merge_bytes({32'b0, dma_sector}, 4, size, wdata);
              dma_sector = merged[31:0];
            end
            REG_COUNT: begin
              merged = merge_bytes({32'b0, dma_count}, 4, size, wdata);
              dma_count = merged[31:0];
            end
            REG_DIRECTION: begin
              merged = merge_bytes({56'b0, dma_dir}, 1, size, wdata);
              dma_dir = merged[7:0];
            end
            default: r.error = ERR_UNMAPPED;
          endcase
        end
      end
      OP_TICK: begin
        period   = (slot_period == 16'd0) ? 32'd1 : {16'b0, slot_period};
        next_cnt = {16'b0, tick_cnt} + 32'd1;
        slot     = (next_cnt % period) == 32'd0;
        tick_cnt = slot ? 16'd0 : next_cnt[15:0];
        if (slot && pending_tags.size() != 0) begin
          r.issue_tag = pending_tags[0];
          if (dma_addr[2:0] != 3'b000) r.error = ERR_ALIGN;
          else if (dma_count == 32'd0 || dma_count > {16'b0, len_limit}) r.error = ERR_LENGTH;
          else if (dma_sector > disk_sectors || dma_count > disk_sectors - dma_sector)
            r.error = ERR_RANGE;
          // a rejected request stays at the head of the pending queue
          if (r.error == ERR_OK) begin
            r.issue         = 1'b1;
            r.issue_write   = (dma_dir != 8'd0);
            r.issue_address = dma_addr;
            r.issue_sector  = dma_sector;
            r.issue_count   = dma_count;
            irq_q = 1'b1;
            done_tags.push_back(pending_tags.pop_front());
          end
        end
      end
      default: ;
    endcase
    r.irq = irq_q;
  endtask

  always @(posedge clk_i) begin
    dev_resp_t want;
    dev_resp_t seen;
    if (!rst_ni) begin
      reset_model();
      awaited_resps.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SECTOR_COUNT: disk_sectors = cfg_wdata_i;
          CFG_MAX_LENGTH:   len_limit    = cfg_wdata_i[15:0];
          CFG_TICK_PERIOD:  slot_period  = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen = '{out_mon_i.rdata, out_mon_i.error, out_mon_i.irq, out_mon_i.issue,
                 out_mon_i.issue_write, out_mon_i.issue_address, out_mon_i.issue_sector,
                 out_mon_i.issue_count, out_mon_i.issue_tag};
        if (awaited_resps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with nothing awaited: rdata=%h err=%0d", $realtime,
                     seen.rdata, seen.error);
        end else begin
          want = awaited_resps.pop_front();
          if (seen.rdata !== want.rdata || seen.error !== want.error || seen.irq !== want.irq ||
              seen.issue !== want.issue || seen.issue_write !== want.issue_write ||
              seen.issue_address !== want.issue_address ||
              seen.issue_sector !== want.issue_sector ||
              seen.issue_count !== want.issue_count || seen.issue_tag !== want.issue_tag) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected rdata=%h err=%0d irq=%b iss=%b wr=%b adr=%h",
                       $realtime, want.rdata, want.error, want.irq, want.issue,
                       want.issue_write, want.issue_address);
              $display("    expected sec=%h cnt=%h tag=%0d",
                       want.issue_sector, want.issue_count, want.issue_tag);
              $display("%0t: mismatch, actual   rdata=%h err=%0d irq=%b iss=%b wr=%b adr=%h",
                       $realtime, seen.rdata, seen.error, seen.irq, seen.issue,
                       seen.issue_write, seen.issue_address);
              $display("    actual   sec=%h cnt=%h tag=%0d",
                       seen.issue_sector, seen.issue_count, seen.issue_tag);
            end
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_response(in_mon_i.op, in_mon_i.addr, in_mon_i.size, in_mon_i.wdata, want);
        awaited_resps.push_back(want);
      end
    end
    awaited_cnt_o = awaited_resps.size();
  end

endmodule

[tb/sv/block_device_tag_controller_unit_tb.sv]
// Testbench top: clock, reset, stimulus and verdict for the block device tag controller.
`timescale 1ns / 1ps
module block_device_tag_controller_unit_tb;
  import bdtc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // op that the block ignores
  localparam int PhaseItems = 120;
  localparam int HoldCycles = 250;

  typedef enum int {SINK_FREE, SINK_COIN, SINK_BEAT, SINK_SLOW} sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  int mismatch_cnt;
  int awaited_cnt;
  bit hold_req = 1'b0;

  // copy of the current configuration, used only to shape requests
  logic [31:0] stim_sectors = '0;
  logic [15:0] stim_max_len = 16'd8;

  bdtc_in_if  in_ch ();
  bdtc_out_if out_ch ();

  block_device_tag_controller_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  bdtc_response_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_mon_i       (in_ch),
    .out_mon_i      (out_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .awaited_cnt_o  (awaited_cnt)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // result side: changing stall patterns, plus one long hold-off on request
  initial begin : sink_side
    sink_mode_e mode;
    int mode_left;
    int hold_left;
    int beat;
    mode = SINK_FREE;
    mode_left = 0;
    beat = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_left = HoldCycles;
        while (hold_left > 0) begin
          @(negedge clk_i);
          hold_left--;
        end
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        beat++;
        case (mode)
          SINK_FREE: out_ch.ready <= 1'b1;
          SINK_COIN: out_ch.ready <= ($urandom_range(0, 1) == 0);
          SINK_BEAT: out_ch.ready <= (beat % 4 != 3);
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_item(input logic [1:0] op, input logic [11:0] addr,
                           input logic [3:0] size, input logic [63:0] wdata);
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.addr  <= addr;
    in_ch.size  <= size;
    in_ch.wdata <= wdata;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (awaited_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_config(input logic [31:0] sectors, input logic [31:0] max_len,
                             input logic [31:0] period);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SECTOR_COUNT;
    cfg_wdata_i <= sectors;
    @(negedge clk_i);
    cfg_index_i <= CFG_MAX_LENGTH;
    cfg_wdata_i <= max_len;
    @(negedge clk_i);
    cfg_index_i <= CFG_TICK_PERIOD;
    cfg_wdata_i <= period;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    stim_sectors = sectors;
    stim_max_len = max_len[15:0];
  endtask

  // mostly well-formed request traffic with random content, some noise
  task automatic draw_item(output logic [1:0] op, output logic [11:0] addr,
                           output logic [3:0] size, output logic [63:0] wdata);
    int pick;
    int roll;
    int unsigned span;
    int unsigned top_sector;
    pick  = $urandom_range(0, 99);
    span  = (stim_max_len == 16'd0) ? 1 : ((stim_max_len < 16'd32) ? stim_max_len : 32);
    op    = OP_READ;
    addr  = REG_REQUEST;
    size  = 4'($urandom_range(1, 8));
    wdata = {$urandom, $urandom};
    if (pick < 30) begin
      op = OP_TICK;
    end else if (pick < 44) begin
      addr = REG_REQUEST;
    end else if (pick < 58) begin
      addr = REG_COMPLETE;
    end else if (pick < 80) begin
      op = OP_WRITE;
      case ($urandom_range(0, 3))
        0: begin
          addr = REG_ADDRESS;
          size = 4'd8;
          if ($urandom_range(0, 9) != 0) wdata[2:0] = 3'b000;
        end
        1: begin
          addr = REG_SECTOR;
          size = 4'($urandom_range(4, 8));
          top_sector = (stim_sectors > span) ? stim_sectors - span : 0;
          wdata[31:0] = $urandom_range(0, top_sector);
        end
        2: begin
          addr = REG_COUNT;
          size = 4'($urandom_range(4, 8));
          roll = $urandom_range(0, 9);
          if (roll == 0) wdata[31:0] = '0;
          else if (roll == 1) wdata[31:0] = {16'b0, stim_max_len} + 32'd1;
          else wdata[31:0] = $urandom_range(1, span);
        end
        default: begin
          addr = REG_DIRECTION;
          if ($urandom_range(0, 1) == 0) wdata[7:0] = 8'h00;
        end
      endcase
    end else if (pick < 88) begin
      size = 4'($urandom_range(0, 8));
      case ($urandom_range(0, 3))
        0: addr = REG_IDLE_CNT;
        1: addr = REG_DONE_CNT;
        2: addr = REG_SECTORS;
        default: addr = REG_MAX_LEN;
      endcase
    end else begin
      op   = 2'($urandom_range(0, 3));
      addr = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 4095))
                                         : 12'($urandom_range(0, 31));
      size = 4'($urandom_range(0, 15));
    end
  endtask

  task automatic run_phase(input logic [31:0] sectors, input logic [31:0] max_len,
                           input logic [31:0] period, input bit squeeze);
    logic [1:0]  op;
    logic [11:0] addr;
    logic [3:0]  size;
    logic [63:0] wdata;
    int burst_left;
    int flow_left;
    wait_drained();
    load_config(sectors, max_len, period);
    burst_left = 0;
    flow_left = 0;
    if (squeeze) begin
      // result side holds off while items keep coming back to back
      hold_req = 1'b1;
      flow_left = 48;
    end
    for (int k = 0; k < PhaseItems; k++) begin
      draw_item(op, addr, size, wdata);
      send_item(op, addr, size, wdata);
      if (flow_left > 0) begin
        flow_left--;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        pause_sender($urandom_range(0, 5));
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic directed_items();
    // reset configuration: no sectors, max length 8, period 1
    send_item(OP_READ, REG_IDLE_CNT, 4'd8, '0);
    send_item(OP_READ, REG_COMPLETE, 4'd8, '0);
    send_item(OP_READ, REG_MAX_LEN, 4'd2, '0);
    send_item(OP_READ, REG_SECTORS, 4'd4, '1);
    send_item(OP_READ, 12'hFFF, 4'd1, '0);
    send_item(OP_READ, REG_ADDRESS, 4'd8, '0);
    send_item(OP_WRITE, REG_REQUEST, 4'd1, '1);
    send_item(OP_WRITE, REG_ADDRESS, 4'd15, '1);
    send_item(OP_READ, REG_IDLE_CNT, 4'd9, '0);
    send_item(OP_NONE, 12'hFFF, 4'd15, '1);
    send_item(OP_READ, REG_REQUEST, 4'd0, '0);
    send_item(OP_TICK, '0, '0, '0);                       // zero count
    send_item(OP_WRITE, REG_COUNT, 4'd8, 64'hFFFF_FFFF_0000_0001);
    send_item(OP_TICK, '0, '0, '0);                       // beyond an empty image
    send_item(OP_WRITE, REG_ADDRESS, 4'd8, 64'hFFFF_FFFF_FFFF_FFFB);
    send_item(OP_TICK, '0, '0, '0);                       // misaligned
    send_item(OP_WRITE, REG_ADDRESS, 4'd1, 64'h0000_0000_0000_00F8);
    send_item(OP_WRITE, REG_SECTOR, 4'd0, '1);
    send_item(OP_READ, REG_IDLE_CNT, 4'd0, '0);
    wait_drained();
    // largest image and length, zero period behaves as one
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_WRITE, REG_SECTOR, 4'd4, 64'h1234_5678_FFFF_FFFE);
    send_item(OP_WRITE, REG_DIRECTION, 4'd8, 64'hFFFF_FFFF_FFFF_FF01);
    send_item(OP_TICK, '0, '0, '0);                       // last sector of the image
    send_item(OP_READ, REG_DONE_CNT, 4'd1, '0);
    send_item(OP_READ, REG_COMPLETE, 4'd8, '0);
    send_item(OP_READ, REG_COMPLETE, 4'd8, '0);
  endtask

  initial begin
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_SECTOR_COUNT;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_READ;
    in_ch.addr  = '0;
    in_ch.size  = '0;
    in_ch.wdata = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_items();
    run_phase(32'd1000, 32'd16, 32'd2, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'd65535, 32'd1, 1'b0);
    run_phase(32'd0, 32'd1, 32'd3, 1'b0);
    run_phase(32'd64, 32'd1, 32'd0, 1'b0);
    run_phase(32'd4096, 32'hABCD_0010, 32'd65535, 1'b0);
    run_phase(32'd200, 32'd8, 32'hFFFF_0004, 1'b0);
    run_phase($urandom_range(1, 100000), $urandom_range(1, 64), $urandom_range(1, 7), 1'b0);
    wait_drained();

    if (mismatch_cnt == 0 && awaited_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
